/* design/vvr_pkg.sv */
// ----------------------------------------------------------------------------
// vvr_pkg
// Shared constants and pipeline side-band types for the vector-to-vector
// rotation matrix block.
// ----------------------------------------------------------------------------
package vvr_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  // divider geometry: numerator, denominator and quotient magnitude widths
  localparam int DIV_NW  = 50;
  localparam int DIV_DW  = 33;
  localparam int DIV_QW  = 20;
  localparam int QUO_W   = DIV_QW + 2;
  localparam int DIV_LAT = DIV_QW + 2;

  localparam int E_W    = 21;
  localparam int C_W    = 20;
  localparam int UMAG_W = 16;

  // symmetric index pairs: diagonal first, then xy, xz, yz
  localparam int PAIR_I [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_J [6] = '{0, 1, 2, 1, 2, 2};

  typedef logic signed [E_W-1:0]   e_t;
  typedef logic signed [C_W-1:0]   c_t;
  typedef logic signed [QUO_W-1:0] quo_t;

  typedef struct packed {
    logic                      near;
    e_t                        e;
    c_t [2:0]                  c;
    logic [2:0][UMAG_W-1:0]    umag;
    logic [2:0]                uneg;
    logic [DIV_DW-1:0]         uu;
  } side1_t;

  typedef struct packed {
    logic       near;
    e_t         e;
    c_t [2:0]   c;
    quo_t [5:0] sym;
    quo_t [5:0] t2;
  } side2_t;

endpackage

/* design/vector_to_vector_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// vector_to_vector_rotation_matrix
// Rotation matrix taking a source unit vector onto a target unit vector,
// Q2.14 in and out, with a two-reflection form for near-parallel pairs.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         start / busy           src_x/y/z_i, dst_x/y/z_i
//  result    out        done_o strobe          m0..m10_o, near_parallel_o
//  config    in         cfg_we_i               cfg_wdata_i (parallel tolerance)
//
//  One pair enters per cycle; busy stays low. Each result passes through
//  five front stages, two 22-stage divider banks (one quotient bit per
//  stage) with a numerator stage between, and an output register. Reset
//  clears the valid chain and sets the tolerance to 1.
//  Results are not held back; the receiver takes each on its strobe cycle.
// ----------------------------------------------------------------------------
module vector_to_vector_rotation_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic signed [15:0] src_x_i,
  input  logic signed [15:0] src_y_i,
  input  logic signed [15:0] src_z_i,
  input  logic signed [15:0] dst_x_i,
  input  logic signed [15:0] dst_y_i,
  input  logic signed [15:0] dst_z_i,
  output logic               done_o,
  output logic signed [15:0] m0_o,
  output logic signed [15:0] m1_o,
  output logic signed [15:0] m2_o,
  output logic signed [15:0] m4_o,
  output logic signed [15:0] m5_o,
  output logic signed [15:0] m6_o,
  output logic signed [15:0] m8_o,
  output logic signed [15:0] m9_o,
  output logic signed [15:0] m10_o,
  output logic               near_parallel_o
);

  import vvr_pkg::*;

  localparam int LAT = 7 + 2 * DIV_LAT;

  function automatic int symk(input int i, input int j);
    int k;
    k = 0;
    for (int n = 0; n < 6; n++) begin
      if ((PAIR_I[n] == i && PAIR_J[n] == j) || (PAIR_I[n] == j && PAIR_J[n] == i)) begin
        k = n;
      end
    end
    return k;
  endfunction

  function automatic logic [15:0] clamp(input logic signed [24:0] x);
    logic [15:0] r;
    if (x > 25'(ONE)) begin
      r = 16'(ONE);
    end else if (x < -25'(ONE)) begin
      r = 16'(-ONE);
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  logic        accept;
  logic [14:0] tol_q;
  logic [4:0]  vld_q;
  logic        vld_p_q;
  logic        ph1_vld;
  logic        ph2_vld;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- stage 1: operands and outer products
  logic signed [15:0] a_in [3];
  logic signed [15:0] b_in [3];
  logic signed [15:0] a1_q [3];
  logic signed [15:0] b1_q [3];
  logic signed [31:0] p1_q [3][3];

  assign a_in = '{src_x_i, src_y_i, src_z_i};
  assign b_in = '{dst_x_i, dst_y_i, dst_z_i};

  // ---------------- stage 2: dot, cross, reflection vectors
  logic [16:0]        aabs [3];
  logic [1:0]         axis;
  logic signed [33:0] dot2_q;
  logic signed [32:0] cr2_q [3];
  logic signed [17:0] u2_q [3];
  logic signed [17:0] v2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aabs[i] = a1_q[i][15] ? 17'd0 - 17'(a1_q[i]) : 17'(a1_q[i]);
    end
    if (aabs[0] < aabs[1]) begin
      axis = (aabs[0] < aabs[2]) ? 2'd0 : 2'd2;
    end else begin
      axis = (aabs[1] < aabs[2]) ? 2'd1 : 2'd2;
    end
  end

  // ---------------- stage 3: parallel test, rounding, pair products
  logic [32:0]        adot;
  logic [33:0]        er;
  logic [19:0]        emag;
  logic signed [30:0] thr;
  logic signed [16:0] margin;
  logic [31:0]        cabs [3];
  logic [32:0]        cr   [3];
  logic [18:0]        cmag [3];
  logic               near3_q;
  e_t                 e3_q;
  c_t                 c3_q [3];
  logic signed [17:0] u3_q [3];
  logic signed [17:0] v3_q [3];
  logic signed [35:0] uup3_q [6];
  logic signed [35:0] vvp3_q [6];
  logic signed [35:0] uvp3_q [3];

  assign adot   = 33'(dot2_q[33] ? -dot2_q : dot2_q);
  assign er     = 34'(adot) + 34'(HALF);
  assign emag   = er[33:FRAC_BITS];
  assign margin = 17'(ONE) - $signed({2'b00, tol_q});
  assign thr    = {margin, {FRAC_BITS{1'b0}}};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cabs[i] = 32'(cr2_q[i][32] ? -cr2_q[i] : cr2_q[i]);
      cr[i]   = 33'(cabs[i]) + 33'(HALF);
      cmag[i] = cr[i][32:FRAC_BITS];
    end
  end

  // ---------------- stage 4: sums, denominators, numerators
  logic signed [37:0] uusum;
  logic signed [37:0] vvsum;
  logic signed [37:0] uvsum;
  logic signed [21:0] dsum;
  logic [18:0]        cab4 [3];
  logic [31:0]        uuabs [6];
  logic [31:0]        vvabs [6];
  logic               near4_q;
  e_t                 e4_q;
  c_t                 c4_q [3];
  logic [DIV_DW-1:0]  uu4_q;
  logic [DIV_DW-1:0]  vv4_q;
  logic [32:0]        uvmag4_q;
  logic               uvneg4_q;
  logic [18:0]        d4_q;
  logic [37:0]        ccmag4_q [6];
  logic [5:0]         ccneg4_q;
  logic [46:0]        t1mag4_q [6];
  logic [5:0]         t1neg4_q;
  logic [46:0]        t2mag4_q [6];
  logic [5:0]         t2neg4_q;
  logic [UMAG_W-1:0]  umag4_q [3];
  logic [2:0]         uneg4_q;
  logic [UMAG_W-1:0]  vmag4_q [3];
  logic [2:0]         vneg4_q;

  assign uusum = 38'(uup3_q[0]) + 38'(uup3_q[1]) + 38'(uup3_q[2]);
  assign vvsum = 38'(vvp3_q[0]) + 38'(vvp3_q[1]) + 38'(vvp3_q[2]);
  assign uvsum = 38'(uvp3_q[0]) + 38'(uvp3_q[1]) + 38'(uvp3_q[2]);
  assign dsum  = 22'(ONE) + 22'(e3_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cab4[i] = 19'(c3_q[i][C_W-1] ? -c3_q[i] : c3_q[i]);
    end
    for (int k = 0; k < 6; k++) begin
      uuabs[k] = 32'(uup3_q[k][35] ? -uup3_q[k] : uup3_q[k]);
      vvabs[k] = 32'(vvp3_q[k][35] ? -vvp3_q[k] : vvp3_q[k]);
    end
  end

  // ---------------- stage 5: divider operands for the first bank
  logic [DIV_NW-1:0] symnum5_q [6];
  logic [5:0]        symneg5_q;
  logic [DIV_DW-1:0] symden5_q;
  logic [DIV_NW-1:0] t2num5_q [6];
  logic [5:0]        t2neg5_q;
  logic [DIV_DW-1:0] vv5_q;
  logic [DIV_NW-1:0] cinum5_q [3];
  logic [2:0]        cineg5_q;
  side1_t            sd5_q;
  side1_t            sd1_q [DIV_LAT];

  // ---------------- first divider bank
  quo_t symq [6];
  quo_t t2q  [6];
  quo_t ciq  [3];

  for (genvar k = 0; k < 6; k++) begin : g_sym
    if (k == 0) begin : g_first
      vvr_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div (
        .clk_i, .rst_ni, .in_valid_i(vld_q[4]), .num_i(symnum5_q[k]),
        .den_i(symden5_q), .neg_i(symneg5_q[k]), .out_valid_o(ph1_vld), .quo_o(symq[k])
      );
    end else begin : g_rest
      vvr_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div (
        .clk_i, .rst_ni, .in_valid_i(vld_q[4]), .num_i(symnum5_q[k]),
        .den_i(symden5_q), .neg_i(symneg5_q[k]), .out_valid_o(), .quo_o(symq[k])
      );
    end
    vvr_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_t2 (
      .clk_i, .rst_ni, .in_valid_i(vld_q[4]), .num_i(t2num5_q[k]),
      .den_i(vv5_q), .neg_i(t2neg5_q[k]), .out_valid_o(), .quo_o(t2q[k])
    );
  end

  for (genvar i = 0; i < 3; i++) begin : g_ci
    vvr_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div (
      .clk_i, .rst_ni, .in_valid_i(vld_q[4]), .num_i(cinum5_q[i]),
      .den_i(vv5_q), .neg_i(cineg5_q[i]), .out_valid_o(), .quo_o(ciq[i])
    );
  end

  // ---------------- numerator stage for the cross reflection term
  side1_t            s1o;
  logic [QUO_W-2:0]  cimag [3];
  logic [36:0]       cu [9];
  logic [DIV_NW-1:0] t3num_q [9];
  logic [8:0]        t3neg_q;
  logic [DIV_DW-1:0] uup_q;
  side2_t            sdp_q;
  side2_t            sd2_q [DIV_LAT];

  assign s1o = sd1_q[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cimag[i] = (QUO_W-1)'(ciq[i][QUO_W-1] ? -ciq[i] : ciq[i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cu[i*3+j] = 37'(cimag[i]) * 37'(s1o.umag[j]);
      end
    end
  end

  // ---------------- second divider bank
  quo_t t3q [9];

  for (genvar n = 0; n < 9; n++) begin : g_t3
    if (n == 0) begin : g_first
      vvr_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div (
        .clk_i, .rst_ni, .in_valid_i(vld_p_q), .num_i(t3num_q[n]),
        .den_i(uup_q), .neg_i(t3neg_q[n]), .out_valid_o(ph2_vld), .quo_o(t3q[n])
      );
    end else begin : g_rest
      vvr_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div (
        .clk_i, .rst_ni, .in_valid_i(vld_p_q), .num_i(t3num_q[n]),
        .den_i(uup_q), .neg_i(t3neg_q[n]), .out_valid_o(), .quo_o(t3q[n])
      );
    end
  end

  // ---------------- final sums and clamp
  side2_t             s2o;
  logic signed [24:0] r [9];
  logic signed [24:0] ef;
  logic signed [24:0] cf [3];
  logic signed [24:0] hf [6];

  assign s2o = sd2_q[DIV_LAT-1];

  always_comb begin
    ef = 25'($signed(s2o.e));
    for (int i = 0; i < 3; i++) begin
      cf[i] = 25'($signed(s2o.c[i]));
    end
    for (int k = 0; k < 6; k++) begin
      hf[k] = 25'($signed(s2o.sym[k]));
    end
    if (s2o.near) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r[i*3+j] = ((i == j) ? 25'(ONE) : 25'sd0) + 25'(t3q[i*3+j])
                     - 25'($signed(s2o.t2[symk(i, j)])) - hf[symk(i, j)];
        end
      end
    end else begin
      r[0] = ef + hf[0];
      r[1] = hf[3] - cf[2];
      r[2] = hf[4] + cf[1];
      r[3] = hf[3] + cf[2];
      r[4] = ef + hf[1];
      r[5] = hf[5] - cf[0];
      r[6] = hf[4] - cf[1];
      r[7] = hf[5] + cf[0];
      r[8] = ef + hf[2];
    end
  end

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= 15'd1;
      vld_q   <= '0;
      vld_p_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      vld_q   <= {vld_q[3:0], accept};
      vld_p_q <= ph1_vld;
      done_o  <= ph2_vld;
    end
  end

  // ---------------- datapath registers
  always_ff @(posedge clk_i) begin
    // stage 1
    for (int i = 0; i < 3; i++) begin
      a1_q[i] <= a_in[i];
      b1_q[i] <= b_in[i];
      for (int j = 0; j < 3; j++) begin
        p1_q[i][j] <= a_in[i] * b_in[j];
      end
    end
    // stage 2
    dot2_q   <= 34'(p1_q[0][0]) + 34'(p1_q[1][1]) + 34'(p1_q[2][2]);
    cr2_q[0] <= 33'(p1_q[1][2]) - 33'(p1_q[2][1]);
    cr2_q[1] <= 33'(p1_q[2][0]) - 33'(p1_q[0][2]);
    cr2_q[2] <= 33'(p1_q[0][1]) - 33'(p1_q[1][0]);
    for (int i = 0; i < 3; i++) begin
      u2_q[i] <= ((axis == 2'(i)) ? 18'(ONE) : 18'sd0) - 18'(a1_q[i]);
      v2_q[i] <= ((axis == 2'(i)) ? 18'(ONE) : 18'sd0) - 18'(b1_q[i]);
    end
    // stage 3
    near3_q <= $signed({2'b00, adot}) > 35'(thr);
    e3_q    <= dot2_q[33] ? -$signed({1'b0, emag}) : $signed({1'b0, emag});
    for (int i = 0; i < 3; i++) begin
      c3_q[i]   <= cr2_q[i][32] ? -$signed({1'b0, cmag[i]}) : $signed({1'b0, cmag[i]});
      u3_q[i]   <= u2_q[i];
      v3_q[i]   <= v2_q[i];
      uvp3_q[i] <= u2_q[i] * v2_q[i];
    end
    for (int k = 0; k < 6; k++) begin
      uup3_q[k] <= u2_q[PAIR_I[k]] * u2_q[PAIR_J[k]];
      vvp3_q[k] <= v2_q[PAIR_I[k]] * v2_q[PAIR_J[k]];
    end
    // stage 4
    near4_q  <= near3_q;
    e4_q     <= e3_q;
    uu4_q    <= uusum[DIV_DW-1:0];
    vv4_q    <= vvsum[DIV_DW-1:0];
    uvneg4_q <= uvsum[37];
    uvmag4_q <= 33'(uvsum[37] ? -uvsum : uvsum);
    d4_q     <= (dsum < 22'sd1) ? 19'd1 : dsum[18:0];
    for (int i = 0; i < 3; i++) begin
      c4_q[i]    <= c3_q[i];
      umag4_q[i] <= UMAG_W'(u3_q[i][17] ? -u3_q[i] : u3_q[i]);
      uneg4_q[i] <= u3_q[i][17];
      vmag4_q[i] <= UMAG_W'(v3_q[i][17] ? -v3_q[i] : v3_q[i]);
      vneg4_q[i] <= v3_q[i][17];
    end
    for (int k = 0; k < 6; k++) begin
      ccmag4_q[k] <= 38'(cab4[PAIR_I[k]]) * 38'(cab4[PAIR_J[k]]);
      ccneg4_q[k] <= c3_q[PAIR_I[k]][C_W-1] ^ c3_q[PAIR_J[k]][C_W-1];
      t1mag4_q[k] <= {uuabs[k], {(FRAC_BITS + 1){1'b0}}};
      t1neg4_q[k] <= uup3_q[k][35];
      t2mag4_q[k] <= {vvabs[k], {(FRAC_BITS + 1){1'b0}}};
      t2neg4_q[k] <= vvp3_q[k][35];
    end
    // stage 5
    symden5_q <= near4_q ? uu4_q : DIV_DW'(d4_q);
    vv5_q     <= vv4_q;
    for (int k = 0; k < 6; k++) begin
      symnum5_q[k] <= near4_q ? DIV_NW'(t1mag4_q[k]) : DIV_NW'(ccmag4_q[k]);
      symneg5_q[k] <= near4_q ? t1neg4_q[k] : ccneg4_q[k];
      t2num5_q[k]  <= DIV_NW'(t2mag4_q[k]);
      t2neg5_q[k]  <= t2neg4_q[k];
    end
    for (int i = 0; i < 3; i++) begin
      cinum5_q[i]    <= DIV_NW'(uvmag4_q) * DIV_NW'(vmag4_q[i]);
      cineg5_q[i]    <= uvneg4_q ^ vneg4_q[i];
      sd5_q.c[i]     <= c4_q[i];
      sd5_q.umag[i]  <= umag4_q[i];
    end
    sd5_q.near <= near4_q;
    sd5_q.e    <= e4_q;
    sd5_q.uneg <= uneg4_q;
    sd5_q.uu   <= uu4_q;
    // side band across the first bank
    sd1_q[0] <= sd5_q;
    for (int n = 1; n < DIV_LAT; n++) begin
      sd1_q[n] <= sd1_q[n-1];
    end
    // numerator stage: |ci u_j| stays below 2^34, times 4 ONE
    uup_q <= s1o.uu;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t3num_q[i*3+j] <= {cu[i*3+j][DIV_NW-FRAC_BITS-3:0], {(FRAC_BITS + 2){1'b0}}};
        t3neg_q[i*3+j] <= ciq[i][QUO_W-1] ^ s1o.uneg[j];
      end
    end
    sdp_q.near <= s1o.near;
    sdp_q.e    <= s1o.e;
    sdp_q.c    <= s1o.c;
    for (int k = 0; k < 6; k++) begin
      sdp_q.sym[k] <= symq[k];
      sdp_q.t2[k]  <= t2q[k];
    end
    // side band across the second bank
    sd2_q[0] <= sdp_q;
    for (int n = 1; n < DIV_LAT; n++) begin
      sd2_q[n] <= sd2_q[n-1];
    end
    // output register
    m0_o            <= clamp(r[0]);
    m1_o            <= clamp(r[1]);
    m2_o            <= clamp(r[2]);
    m4_o            <= clamp(r[3]);
    m5_o            <= clamp(r[4]);
    m6_o            <= clamp(r[5]);
    m8_o            <= clamp(r[6]);
    m9_o            <= clamp(r[7]);
    m10_o           <= clamp(r[8]);
    near_parallel_o <= s2o.near;
  end

  // ---------------- assertions
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result strobe missing after transfer");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe without matching transfer");

  a_diag_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(m0_o) <= ONE && $signed(m0_o) >= -ONE &&
                $signed(m5_o) <= ONE && $signed(m5_o) >= -ONE &&
                $signed(m10_o) <= ONE && $signed(m10_o) >= -ONE))
    else $error("diagonal element outside unit range");

endmodule

/* design/vvr_div.sv */
// ----------------------------------------------------------------------------
// vvr_div
// Pipelined restoring divider, one quotient bit per stage. Rounds half away
// from zero, saturates the magnitude at 2^QW, gives zero for a zero divisor.
// ----------------------------------------------------------------------------
module vvr_div #(
  parameter int NW = 50,
  parameter int DW = 33,
  parameter int QW = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [NW-1:0]        num_i,
  input  logic [DW-1:0]        den_i,
  input  logic                 neg_i,
  output logic                 out_valid_o,
  output logic signed [QW+1:0] quo_o
);

  localparam int CW = NW + DW + QW;

  logic [QW:0]   vld_q;
  logic [QW:0]   neg_q;
  logic [QW:0]   ovf_q;
  logic [QW:0]   zero_q;
  logic [DW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [QW-1:0] low_q [QW+1];

  logic [DW:0]   sh     [1:QW];
  logic          take   [1:QW];
  logic [DW-1:0] rem_nx [1:QW];

  logic          ovf_d;
  logic          up;
  logic [QW:0]   mag;

  // quotient would not fit in QW bits
  assign ovf_d = {{(DW + QW){1'b0}}, num_i} >= CW'({{NW{1'b0}}, den_i, {QW{1'b0}}});

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      sh[k]     = {rem_q[k-1], low_q[k-1][QW-k]};
      take[k]   = sh[k] >= {1'b0, den_q[k-1]};
      rem_nx[k] = take[k] ? DW'(sh[k] - {1'b0, den_q[k-1]}) : sh[k][DW-1:0];
    end
  end

  assign up  = {rem_q[QW], 1'b0} >= {1'b0, den_q[QW]};
  assign mag = zero_q[QW] ? '0 :
               ovf_q[QW]  ? (QW+1)'(1) << QW :
               {1'b0, quo_q[QW]} + (QW+1)'(up);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      vld_q       <= {vld_q[QW-1:0], in_valid_i};
      out_valid_o <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= DW'(num_i[NW-1:QW]);
    low_q[0]  <= num_i[QW-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    neg_q[0]  <= neg_i;
    ovf_q[0]  <= ovf_d;
    zero_q[0] <= (den_i == '0);
    for (int k = 1; k <= QW; k++) begin
      rem_q[k]  <= rem_nx[k];
      low_q[k]  <= low_q[k-1];
      quo_q[k]  <= {quo_q[k-1][QW-2:0], take[k]};
      den_q[k]  <= den_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      ovf_q[k]  <= ovf_q[k-1];
      zero_q[k] <= zero_q[k-1];
    end
    quo_o <= neg_q[QW] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule
